FILE: hw/rtl/skvt_pkg.sv
// Package for the sorted key/value table: sizes, entry type, mode and status codes.
// Used by the entry store and the top level. No dependencies.
package skvt_pkg;

	localparam int DEPTH       = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int KEY_W       = 64;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);

	typedef logic [VALUE_WIDTH-1:0] val_t;
	typedef logic [KEY_W-1:0]       key_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef struct packed {
		key_t key;
		val_t val;
	} entry_t;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_UPDATED  = 3'd1;
	localparam logic [2:0] ST_FOUND    = 3'd2;
	localparam logic [2:0] ST_MISSING  = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_CLEARED  = 3'd5;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value_out;
		logic [63:0] key_out;
		logic [6:0]  entry_count;
	} result_t;

endpackage

FILE: hw/rtl/skvt_if.sv
// Request and response channel interfaces for the sorted key/value table.
// Plain valid/ready channels; no package dependency.
interface skvt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] key;
	logic [31:0] value_in;
	logic [5:0]  position;

	modport source (output valid, mode, key, value_in, position, input ready);
	modport sink   (input valid, mode, key, value_in, position, output ready);
endinterface

interface skvt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] value_out;
	logic [63:0] key_out;
	logic [6:0]  entry_count;

	modport source (output valid, status, value_out, key_out, entry_count, input ready);
	modport sink   (input valid, status, value_out, key_out, entry_count, output ready);
endinterface

FILE: hw/rtl/skvt_mem.sv
// Entry store: one write port, one read port, registered read data.
// Depends on skvt_pkg for the entry type and depth.
module skvt_mem (
	input  logic            clk,
	input  logic            we,
	input  skvt_pkg::idx_t  waddr,
	input  skvt_pkg::entry_t wdata,
	input  skvt_pkg::idx_t  raddr,
	output skvt_pkg::entry_t rdata
);

	skvt_pkg::entry_t mem_q [skvt_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/sorted_key_value_table.sv
// Top level of the sorted key/value table: control sequencer around the entry store.
// Depends on skvt_pkg, skvt_req_if / skvt_rsp_if and skvt_mem.
//
//  channel | dir | fields
//  --------+-----+----------------------------------------------
//  req     | in  | mode, key, value_in, position
//  rsp     | out | status, value_out, key_out, entry_count
//
// One request is worked at a time; req.ready is high only while the sequencer idles.
// Binary search reads the middle entry of each probe on the single read port (S_SRCH), then
// compares it (S_CMP); an insert then moves one entry per cycle up, from fill down to the slot.
// The result sits in an output register, so one further request is taken while rsp stalls.
// Reset clears the count and control; the store itself holds no reset.
module sorted_key_value_table (
	input  logic            clk,
	input  logic            arst_n,
	skvt_req_if.sink        req,
	skvt_rsp_if.source      rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_RDPOS = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]          state_q;
	logic [1:0]          mode_q;
	skvt_pkg::key_t      key_q;
	skvt_pkg::val_t      val_q;
	skvt_pkg::cnt_t      fill_q;
	skvt_pkg::cnt_t      lo_q;
	skvt_pkg::cnt_t      hi_q;
	skvt_pkg::cnt_t      mid_q;
	skvt_pkg::cnt_t      slot_q;
	skvt_pkg::cnt_t      cnt_q;
	logic                shift_v_s1;
	skvt_pkg::idx_t      wa_s1;
	skvt_pkg::result_t   res_q;
	skvt_pkg::result_t   out_q;
	logic                out_vld_q;

	logic                mem_we;
	skvt_pkg::idx_t      mem_waddr;
	skvt_pkg::entry_t    mem_wdata;
	skvt_pkg::idx_t      mem_raddr;
	skvt_pkg::entry_t    mem_rdata;
	skvt_pkg::cnt_t      mid_c;
	logic                accept;
	logic                pos_ok;

	skvt_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
	assign pos_ok    = 32'(req.position) < 32'(fill_q);

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = mid_q[skvt_pkg::IDX_W-1:0];
		mem_wdata = '{key: mem_rdata.key, val: val_q};
		mem_raddr = mid_c[skvt_pkg::IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				mem_raddr = skvt_pkg::IDX_W'(req.position);
			end
			S_CMP: begin
				// update in place on a duplicate key
				mem_we = (mode_q == skvt_pkg::MODE_INSERT) && (mem_rdata.key == key_q);
			end
			S_SHIFT: begin
				mem_raddr = skvt_pkg::IDX_W'(cnt_q - skvt_pkg::cnt_t'(1));
				if (shift_v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = wa_s1;
					mem_wdata = mem_rdata;
				end else if (cnt_q == slot_q) begin
					mem_we    = 1'b1;
					mem_waddr = slot_q[skvt_pkg::IDX_W-1:0];
					mem_wdata = '{key: key_q, val: val_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			shift_v_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_vld_q && rsp.ready && (state_q != S_RESP)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q <= req.mode;
						key_q  <= req.key;
						val_q  <= skvt_pkg::val_t'(req.value_in);
						lo_q   <= '0;
						hi_q   <= fill_q;
						res_q  <= '{status: (req.mode == skvt_pkg::MODE_CLEAR) ?
								skvt_pkg::ST_CLEARED : skvt_pkg::ST_MISSING,
							value_out: '0, key_out: '0,
							entry_count: (req.mode == skvt_pkg::MODE_CLEAR) ?
								7'd0 : 7'(fill_q)};
						unique case (req.mode)
							skvt_pkg::MODE_INSERT, skvt_pkg::MODE_LOOKUP: begin
								state_q <= S_SRCH;
							end
							skvt_pkg::MODE_READ: begin
								state_q <= pos_ok ? S_RDPOS : S_RESP;
							end
							skvt_pkg::MODE_CLEAR: begin
								fill_q  <= '0;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_c;
						state_q <= S_CMP;
					end else if (mode_q == skvt_pkg::MODE_LOOKUP) begin
						state_q <= S_RESP;
					end else if (fill_q == skvt_pkg::cnt_t'(skvt_pkg::DEPTH)) begin
						res_q.status <= skvt_pkg::ST_FULL;
						state_q      <= S_RESP;
					end else begin
						slot_q     <= lo_q;
						cnt_q      <= fill_q;
						shift_v_s1 <= 1'b0;
						state_q    <= S_SHIFT;
					end
				end
				S_CMP: begin
					priority if (mem_rdata.key < key_q) begin
						lo_q    <= mid_q + skvt_pkg::cnt_t'(1);
						state_q <= S_SRCH;
					end else if (mem_rdata.key > key_q) begin
						hi_q    <= mid_q;
						state_q <= S_SRCH;
					end else begin
						if (mode_q == skvt_pkg::MODE_INSERT) begin
							res_q.status <= skvt_pkg::ST_UPDATED;
						end else begin
							res_q <= '{status: skvt_pkg::ST_FOUND,
								value_out: 32'(mem_rdata.val), key_out: '0,
								entry_count: res_q.entry_count};
						end
						state_q <= S_RESP;
					end
				end
				S_SHIFT: begin
					// read entry cnt-1 now, write it to cnt next cycle
					if (cnt_q != slot_q) begin
						shift_v_s1 <= 1'b1;
						wa_s1      <= cnt_q[skvt_pkg::IDX_W-1:0];
						cnt_q      <= cnt_q - skvt_pkg::cnt_t'(1);
					end else if (shift_v_s1) begin
						shift_v_s1 <= 1'b0;
					end else begin
						fill_q  <= fill_q + skvt_pkg::cnt_t'(1);
						res_q   <= '{status: skvt_pkg::ST_INSERTED, value_out: '0,
							key_out: '0, entry_count: 7'(fill_q + skvt_pkg::cnt_t'(1))};
						state_q <= S_RESP;
					end
				end
				S_RDPOS: begin
					res_q   <= '{status: skvt_pkg::ST_FOUND, value_out: 32'(mem_rdata.val),
						key_out: mem_rdata.key, entry_count: res_q.entry_count};
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_vld_q || rsp.ready) begin
						out_q     <= res_q;
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_q.status;
	assign rsp.value_out   = out_q.value_out;
	assign rsp.key_out     = out_q.key_out;
	assign rsp.entry_count = out_q.entry_count;

endmodule
